FILE: src/assert_macros.svh
// assertion macros included by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MTR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MTR_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mtr_pkg.sv
// package: widths, exponent constants and sequencer state type
package mtr_pkg;

   localparam int DATA_W    = 64;   // candidate and residue field width
   localparam int EXP_START = 8;    // first exponent bit handled by square-and-double
   localparam int EXP_TOP   = 127;  // mersenne exponent
   localparam int START_POW = 255;  // seed is 2^255 mod q
   localparam int STEPS     = EXP_TOP - EXP_START;
   localparam int PRE_W     = 8;    // holds 0 .. START_POW-1
   localparam int ITER_W    = 7;    // holds 0 .. STEPS-1

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_MUL,
      ST_DBL,
      ST_FIN
   } state_type;

endpackage

FILE: src/mtr_if.sv
// valid/ready channel interfaces for candidate and residue beats
interface mtr_req_if;
   import mtr_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface mtr_rsp_if;
   import mtr_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] residue;
   logic              bad_input;

   modport source (output valid, output residue, output bad_input, input ready);
   modport sink   (input valid, input residue, input bad_input, output ready);
endinterface

FILE: src/mtr_moddbl.sv
// shared modular unit: z = (2*x + y) mod q for x, y < q
module mtr_moddbl #(
   parameter int Q_BITS = 64
) (
   input  logic [Q_BITS-1:0] x,
   input  logic [Q_BITS-1:0] y,
   input  logic [Q_BITS-1:0] q,
   output logic [Q_BITS-1:0] z
);
   logic [Q_BITS+1:0] sum;
   logic [Q_BITS+1:0] q1;
   logic [Q_BITS+1:0] q2;
   logic [Q_BITS+1:0] red;

   // sum stays below 3q, so at most one of q or 2q comes off
   always_comb begin
      sum = {1'b0, x, 1'b0} + {2'b00, y};
      q1  = {2'b00, q};
      q2  = {1'b0, q, 1'b0};
      if (sum >= q2) begin
         red = sum - q2;
      end else if (sum >= q1) begin
         red = sum - q1;
      end else begin
         red = sum;
      end
      z = red[Q_BITS-1:0];
   end

endmodule

FILE: src/mersenne_m127_trial_residue.sv
// Takes a trial factor q (low Q_BITS bits of candidate) and returns 2^(2^127-1) mod q; a
// residue of 1 means q divides 2^(2^127-1)-1, and a q of zero gives residue 0 with bad_input set.
// One candidate at a time: the single modular add-double unit (2x+y mod q) does all the
// work, one step per cycle: 255 doublings build 2^255 mod q, then each of the 119
// square-and-double steps is a shift-and-add square over the bits of r, from the top,
// followed by one doubling. A zero q goes straight to the output stage. req_ch.ready
// is high only between items; a finished residue waits in the output register while
// the next candidate is accepted.
`include "assert_macros.svh"

module mersenne_m127_trial_residue #(
   parameter int Q_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   mtr_req_if.sink    req_ch,
   mtr_rsp_if.source  rsp_ch
);
   import mtr_pkg::*;

   localparam int BIT_W = (Q_BITS > 1) ? $clog2(Q_BITS) : 1;

   state_type         state_ff, state_in;
   logic [Q_BITS-1:0] q_ff, q_in;
   logic [Q_BITS-1:0] r_ff, r_in;
   logic [Q_BITS-1:0] acc_ff, acc_in;
   logic [PRE_W-1:0]  pre_ff, pre_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              bad_ff, bad_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] residue_ff, residue_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic [Q_BITS-1:0] unit_x;
   logic [Q_BITS-1:0] unit_y;
   logic [Q_BITS-1:0] unit_z;
   logic [Q_BITS-1:0] cand_q;

   mtr_moddbl #(.Q_BITS(Q_BITS)) u_moddbl (
      .x (unit_x),
      .y (unit_y),
      .q (q_ff),
      .z (unit_z)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff       <= q_in;
      r_ff       <= r_in;
      acc_ff     <= acc_in;
      pre_ff     <= pre_in;
      iter_ff    <= iter_in;
      bit_ff     <= bit_in;
      bad_ff     <= bad_in;
      residue_ff <= residue_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      acc_in       = acc_ff;
      pre_in       = pre_ff;
      iter_in      = iter_ff;
      bit_in       = bit_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      residue_in   = residue_ff;
      rsp_bad_in   = rsp_bad_ff;
      cand_q       = req_ch.candidate[Q_BITS-1:0];

      // the square multiplies r by itself, bit by bit from the top
      if (state_ff == ST_MUL || state_ff == ST_DBL) begin
         unit_x = acc_ff;
      end else begin
         unit_x = r_ff;
      end
      if (state_ff == ST_MUL && r_ff[bit_ff]) begin
         unit_y = r_ff;
      end else begin
         unit_y = '0;
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               q_in   = cand_q;
               pre_in = '0;
               if (cand_q == '0) begin
                  bad_in   = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  bad_in   = 1'b0;
                  r_in     = (cand_q == Q_BITS'(1)) ? '0 : Q_BITS'(1);
                  state_in = ST_PRE;
               end
            end
         end
         ST_PRE: begin
            r_in   = unit_z;
            pre_in = pre_ff + PRE_W'(1);
            if (pre_ff == PRE_W'(START_POW - 1)) begin
               acc_in   = '0;
               bit_in   = BIT_W'(Q_BITS - 1);
               iter_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in = unit_z;
            if (bit_ff == '0) begin
               state_in = ST_DBL;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         ST_DBL: begin
            r_in = unit_z;
            if (iter_ff == ITER_W'(STEPS - 1)) begin
               state_in = ST_FIN;
            end else begin
               iter_in  = iter_ff + ITER_W'(1);
               acc_in   = '0;
               bit_in   = BIT_W'(Q_BITS - 1);
               state_in = ST_MUL;
            end
         end
         ST_FIN: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               residue_in   = bad_ff ? '0 : DATA_W'(r_ff);
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.residue   = residue_ff;
   assign rsp_ch.bad_input = rsp_bad_ff;

   `MTR_ASSERT_IMP(a_bad_zero, clock, reset, rsp_valid_ff && rsp_bad_ff, residue_ff == '0, "bad input beat with nonzero residue")
   `MTR_ASSERT_NXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, state_ff != ST_IDLE, "sequencer idle after accepted beat")
   `MTR_ASSERT_IMP(a_reduced, clock, reset, state_ff == ST_MUL || state_ff == ST_DBL, acc_ff < q_ff && r_ff < q_ff, "operand not reduced mod q")

endmodule

FILE: verif/testbench.sv
// testbench for mersenne_m127_trial_residue: directed and random candidates vs a local predictor
`timescale 1ns / 1ps

module testbench;
   import mtr_pkg::*;

   localparam int Q_BITS = 64;
   localparam logic [DATA_W-1:0] Q_MASK = {DATA_W{1'b1}} >> (DATA_W - Q_BITS);
   localparam int TAIL_CYCLES = 40;
   localparam int LONG_HOLD = 20000;

   typedef struct packed {
      logic [DATA_W-1:0] residue;
      logic              bad_input;
   } residue_beat_type;

   logic clock;
   logic reset;

   mtr_req_if req_ch ();
   mtr_rsp_if rsp_ch ();

   mersenne_m127_trial_residue #(.Q_BITS(Q_BITS)) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   residue_beat_type pending_residues[$];
   int               residue_errors = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               stall_hold = 0;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [DATA_W-1:0] add_mod_q(input logic [DATA_W-1:0] x,
                                                   input logic [DATA_W-1:0] y,
                                                   input logic [DATA_W-1:0] q);
      logic [DATA_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, q}) s = s - {1'b0, q};
      return s[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] mul_mod_q(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b,
                                                   input logic [DATA_W-1:0] q);
      logic [DATA_W-1:0] acc;
      acc = '0;
      for (int i = DATA_W - 1; i >= 0; i--) begin
         acc = add_mod_q(acc, acc, q);
         if (b[i]) acc = add_mod_q(acc, a, q);
      end
      return acc;
   endfunction

   // 2^(2^127-1) mod q
   function automatic residue_beat_type m127_residue(input logic [DATA_W-1:0] cand);
      logic [DATA_W-1:0] q;
      logic [DATA_W-1:0] r;
      residue_beat_type  res;
      q = cand & Q_MASK;
      if (q == '0) begin
         res.residue = '0;
         res.bad_input = 1'b1;
         return res;
      end
      r = (q == 64'd1) ? 64'd0 : 64'd1;
      for (int k = 0; k < START_POW; k++) r = add_mod_q(r, r, q);
      // exponent 2^k-1 grows to 2^(k+1)-1
      for (int k = EXP_START; k < EXP_TOP; k++) begin
         r = mul_mod_q(r, r, q);
         r = add_mod_q(r, r, q);
      end
      res.residue = r;
      res.bad_input = 1'b0;
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void note_mismatch(input string what);
      residue_errors++;
      if (residue_errors <= 10) $display("mismatch at %0t: %s", $realtime, what);
   endfunction

   always @(posedge clock) begin : check_beat
      residue_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_residues.size() == 0) begin
            note_mismatch($sformatf("unexpected beat residue=%h bad_input=%b",
                                    rsp_ch.residue, rsp_ch.bad_input));
         end else begin
            want = pending_residues.pop_front();
            if (rsp_ch.residue !== want.residue)
               note_mismatch($sformatf("residue expected %h got %h",
                                       want.residue, rsp_ch.residue));
            if (rsp_ch.bad_input !== want.bad_input)
               note_mismatch($sformatf("bad_input expected %b got %b",
                                       want.bad_input, rsp_ch.bad_input));
         end
      end
   end

   // receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold = stall_hold - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   // valid stays high after a beat so back-to-back candidates need no gap
   task automatic send_candidate(input logic [DATA_W-1:0] cand);
      bit lowered;
      lowered = 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         if (!lowered) begin
            req_ch.valid <= 1'b0;
            lowered = 1'b1;
         end
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.candidate <= cand;
      do @(posedge clock); while (!req_ch.ready);
      pending_residues.push_back(m127_residue(cand));
   endtask

   task automatic req_quiet();
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_quiet();
      while (pending_residues.size() != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] draw_candidate();
      case ($urandom_range(19))
         0:             return '0;
         1, 2, 3, 4:    return DATA_W'($urandom_range(1000, 1));
         5, 6, 7:       return {32'd0, $urandom()};
         8, 9, 10, 11:  return {1'b1, 31'($urandom()), $urandom()};
         default:       return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic test_directed();
      logic [DATA_W-1:0] cases[$];
      cases = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd7, 64'd255, 64'd256,
                64'd0, 64'hFFFF_FFFF, 64'h1_0000_0001, 64'h8000_0000_0000_0000,
                64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFC5,
                64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'd1};
      send_idle_pct = 0;
      recv_stall_pct = 0;
      foreach (cases[i]) send_candidate(cases[i]);
   endtask

   task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_candidate(draw_candidate());
   endtask

   // sender stops until every residue is back, then resumes
   task automatic test_pause_until_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained();
      send_candidate(draw_candidate());
      send_candidate(draw_candidate());
   endtask

   // receiver blocks long enough that the output register fills and input stalls
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained();
      stall_hold = LONG_HOLD;
      repeat (3) send_candidate(draw_candidate());
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.candidate = '0;
      rsp_ch.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix(25, 0, 0);
      test_random_mix(20, 82, 0);
      test_random_mix(20, 0, 82);
      test_random_mix(20, 13, 13);
      test_pause_until_drained();
      test_backpressure();
      test_random_mix(5, 13, 13);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (residue_errors == 0 && pending_residues.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/mtr_pkg.sv
src/mtr_if.sv
src/mtr_moddbl.sv
src/mersenne_m127_trial_residue.sv
verif/testbench.sv
